// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ----- design/ebgs_pkg.sv -----
package ebgs_pkg;

   // Fixed field widths.
   localparam int COORD_W  = 16;
   localparam int SAMPLE_W = 2 * COORD_W;
   localparam int RATIO_W  = 4;
   localparam int GAIN_W   = 4;
   localparam int BIAS_W   = 19;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_RATIO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAZE_GAIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERT_BIAS   = 2'd2;

   // Register values after reset.
   localparam logic [RATIO_W-1:0]       RATIO_RESET = 4'd7;
   localparam logic [GAIN_W-1:0]        GAIN_RESET  = 4'd5;
   localparam logic signed [BIAS_W-1:0] BIAS_RESET  = 19'sd65536;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_DRAIN,
      ST_START,
      ST_DIV,
      ST_DONE
   } ebgs_state_type;

   // Commands to the history store.
   typedef struct packed {
      logic push;
      logic rd_en;
      logic eye;
   } ebgs_hist_cmd_type;

   // Tag that travels with a history read into the mapping stage.
   typedef struct packed {
      logic vld;
      logic in_blink;
      logic in_move;
   } ebgs_tag_type;

   // Status leaving the mapping stage.
   typedef struct packed {
      logic vld;
      logic lost;
   } ebgs_map_stat_type;

endpackage

// ----- design/ebgs_hist.sv -----
module ebgs_hist
   import ebgs_pkg::*;
#(
   parameter int DEPTH = 7,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ebgs_hist_cmd_type       cmd,
   input  logic [SAMPLE_W-1:0]     sample,
   input  logic [IDX_W-1:0]        rd_index,
   output logic [CNT_W-1:0]        count,
   output logic [SAMPLE_W-1:0]     rd_data
);

   localparam int AW = $clog2(2 * DEPTH);

   logic [SAMPLE_W-1:0] mem [2 * DEPTH];
   logic [IDX_W-1:0]    wp_ff [2];
   logic [IDX_W-1:0]    wp_in [2];
   logic [CNT_W-1:0]    cnt_ff [2];
   logic [CNT_W-1:0]    cnt_in [2];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [IDX_W:0]      rd_pos;
   logic [IDX_W-1:0]    rd_slot;
   logic [AW-1:0]       eye_base;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;

   // Each eye owns a ring of DEPTH entries; the write pointer marks the next free slot.
   always_comb begin
      eye_base = cmd.eye ? AW'(DEPTH) : '0;
      wr_addr  = eye_base + AW'(wp_ff[cmd.eye]);
      // The i-th newest sample sits i slots behind the newest one.
      rd_pos = (IDX_W+1)'(wp_ff[cmd.eye]) + (IDX_W+1)'(DEPTH - 1) - (IDX_W+1)'(rd_index);
      if (rd_pos >= (IDX_W+1)'(DEPTH)) begin
         rd_slot = IDX_W'(rd_pos - (IDX_W+1)'(DEPTH));
      end else begin
         rd_slot = IDX_W'(rd_pos);
      end
      rd_addr = eye_base + AW'(rd_slot);
   end

   // Pointer and fill count update on a push.
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         wp_in[e]  = wp_ff[e];
         cnt_in[e] = cnt_ff[e];
         if (cmd.push && (cmd.eye == 1'(e))) begin
            wp_in[e] = (wp_ff[e] == IDX_W'(DEPTH - 1)) ? '0 : wp_ff[e] + 1'b1;
            if (cnt_ff[e] != CNT_W'(DEPTH)) begin
               cnt_in[e] = cnt_ff[e] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff[0]  <= '0;
         wp_ff[1]  <= '0;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
      end else begin
         wp_ff  <= wp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Sample memory with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= sample;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign count   = cnt_ff[cmd.eye];
   assign rd_data = rd_data_ff;

endmodule

// ----- design/ebgs_map.sv -----
module ebgs_map
   import ebgs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ebgs_tag_type             tag,
   input  logic [SAMPLE_W-1:0]      sample,
   input  logic [GAIN_W-1:0]        gain,
   input  logic signed [BIAS_W-1:0] bias,
   output ebgs_map_stat_type        stat,
   output logic signed [COORD_W-1:0] map_x,
   output logic signed [COORD_W-1:0] map_y
);

   localparam int PROD_W = 22;

   ebgs_map_stat_type         stat_ff;
   ebgs_map_stat_type         stat_in;
   logic signed [COORD_W-1:0] map_x_ff;
   logic signed [COORD_W-1:0] map_x_in;
   logic signed [COORD_W-1:0] map_y_ff;
   logic signed [COORD_W-1:0] map_y_in;
   logic [COORD_W-1:0]        vx;
   logic [COORD_W-1:0]        vy;
   logic signed [COORD_W:0]   cx;
   logic signed [COORD_W:0]   cy;
   logic signed [PROD_W-1:0]  gx;
   logic signed [PROD_W-1:0]  gy;
   logic signed [COORD_W-1:0] clx;
   logic signed [COORD_W-1:0] cly;

   // Saturate a wide value to the Q1.15 range.
   function automatic logic signed [COORD_W-1:0] clamp_q15(input logic signed [PROD_W-1:0] t);
      logic signed [COORD_W-1:0] r;
      if (t > PROD_W'(32767)) begin
         r = 16'sh7fff;
      end else if (t < -PROD_W'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = t[COORD_W-1:0];
      end
      return r;
   endfunction

   // Center each coordinate, apply the gain, and add the bias on the vertical axis.
   always_comb begin
      vx  = sample[COORD_W-1:0];
      vy  = sample[SAMPLE_W-1:COORD_W];
      cx  = $signed({1'b0, vx}) - 17'sd32768;
      cy  = $signed({1'b0, vy}) - 17'sd32768;
      gx  = PROD_W'(cx) * PROD_W'($signed({1'b0, gain}));
      gy  = PROD_W'(cy) * PROD_W'($signed({1'b0, gain})) + PROD_W'(bias);
      clx = clamp_q15(gx);
      cly = clamp_q15(gy);
   end

   // Lost coordinates map to zero; the vertical axis is negated with saturation.
   always_comb begin
      stat_in.vld  = tag.vld;
      stat_in.lost = tag.vld && tag.in_blink && (sample == '0);
      map_x_in     = '0;
      map_y_in     = '0;
      if (tag.vld && tag.in_move) begin
         if (vx != '0) begin
            map_x_in = clx;
         end
         if (vy != '0) begin
            map_y_in = (cly == 16'sh8000) ? 16'sh7fff : -cly;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else begin
         stat_ff <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      map_x_ff <= map_x_in;
      map_y_ff <= map_y_in;
   end

   assign stat  = stat_ff;
   assign map_x = map_x_ff;
   assign map_y = map_y_ff;

endmodule

// ----- design/ebgs_div.sv -----
module ebgs_div
   import ebgs_pkg::*;
#(
   parameter int DW = 20,
   parameter int VW = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [DW-1:0]      dividend_x,
   input  logic signed [DW-1:0]      dividend_y,
   input  logic [VW-1:0]             divisor,
   output logic                      done,
   output logic signed [COORD_W-1:0] quot_x,
   output logic signed [COORD_W-1:0] quot_y
);

   // Magnitudes are padded to an even width so two quotient bits retire per cycle.
   localparam int MW    = DW + (DW % 2);
   localparam int STEPS = MW / 2;
   localparam int CW    = $clog2(STEPS + 1);

   logic          busy_ff;
   logic          busy_in;
   logic          done_ff;
   logic          done_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [VW-1:0] dvs_ff;
   logic [VW-1:0] dvs_in;
   logic [VW:0]   rx_ff;
   logic [VW:0]   rx_in;
   logic [VW:0]   ry_ff;
   logic [VW:0]   ry_in;
   logic [MW-1:0] qx_ff;
   logic [MW-1:0] qx_in;
   logic [MW-1:0] qy_ff;
   logic [MW-1:0] qy_in;
   logic          negx_ff;
   logic          negx_in;
   logic          negy_ff;
   logic          negy_in;
   logic [DW-1:0] magx;
   logic [DW-1:0] magy;
   logic [COORD_W-1:0] qlx;
   logic [COORD_W-1:0] qly;

   // Two restoring division steps: shift in a dividend bit, subtract when it fits.
   function automatic logic [VW+MW:0] step2(input logic [VW:0] rem, input logic [MW-1:0] q,
                                            input logic [VW-1:0] d);
      logic [VW:0]   r;
      logic [MW-1:0] qq;
      r  = rem;
      qq = q;
      for (int k = 0; k < 2; k++) begin
         r  = {r[VW-1:0], qq[MW-1]};
         qq = {qq[MW-2:0], 1'b0};
         if (r >= {1'b0, d}) begin
            r     = r - {1'b0, d};
            qq[0] = 1'b1;
         end
      end
      return {r, qq};
   endfunction

   always_comb begin
      magx = dividend_x[DW-1] ? DW'(-dividend_x) : DW'(dividend_x);
      magy = dividend_y[DW-1] ? DW'(-dividend_y) : DW'(dividend_y);
   end

   // Load on start, then step both quotients together until the count runs out.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      negx_in = negx_ff;
      negy_in = negy_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(STEPS);
         dvs_in  = divisor;
         rx_in   = '0;
         ry_in   = '0;
         qx_in   = MW'(magx);
         qy_in   = MW'(magy);
         negx_in = dividend_x[DW-1];
         negy_in = dividend_y[DW-1];
      end else if (busy_ff) begin
         {rx_in, qx_in} = step2(rx_ff, qx_ff, dvs_ff);
         {ry_in, qy_in} = step2(ry_ff, qy_ff, dvs_ff);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff  <= dvs_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      negx_ff <= negx_in;
      negy_ff <= negy_in;
   end

   // The averages always fit Q1.15, so the low bits carry the whole quotient.
   always_comb begin
      qlx    = qx_ff[COORD_W-1:0];
      qly    = qy_ff[COORD_W-1:0];
      quot_x = negx_ff ? -$signed(qlx) : $signed(qlx);
      quot_y = negy_ff ? -$signed(qly) : $signed(qly);
   end

   assign done = done_ff;

endmodule

// ----- design/eye_blink_and_gaze_smoother.sv -----
// Eye blink and gaze smoother. Each request carries one pupil sample for the left or right
// eye; it is stored in that eye's history and one response returns the averaged gaze (Q1.15)
// and the blink flag. The readout covers the samples held for that eye (at most
// max(BLINK_WINDOW, MOVE_WINDOW)), and the divider works on MW, the even-padded width
// of the gaze sum (20 bits at the default windows). The history memory gives one
// sample per cycle to a shared mapping stage, and the divider then retires two quotient bits
// per cycle for both axes. A new request is taken while the previous response still waits.
`include "assert_macros.svh"

module eye_blink_and_gaze_smoother
   import ebgs_pkg::*;
#(
   parameter int BLINK_WINDOW = 7,
   parameter int MOVE_WINDOW  = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_eye_index,
   input  logic [COORD_W-1:0]          req_pupil_in_x,
   input  logic [COORD_W-1:0]          req_pupil_in_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [COORD_W-1:0]   rsp_gaze_x,
   output logic signed [COORD_W-1:0]   rsp_gaze_y,
   output logic                        rsp_blink,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [BIAS_W-1:0]           csr_wdata
);

   localparam int DEPTH = (BLINK_WINDOW > MOVE_WINDOW) ? BLINK_WINDOW : MOVE_WINDOW;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = COORD_W + 1 + $clog2(MOVE_WINDOW);
   localparam int CMP_W = CNT_W + 4;

   ebgs_state_type state_ff;
   ebgs_state_type state_in;

   // Configuration registers.
   logic [RATIO_W-1:0]       ratio_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic signed [BIAS_W-1:0] bias_ff;

   // Request and sequencing registers.
   logic                eye_ff;
   logic [COORD_W-1:0]  px_ff;
   logic [COORD_W-1:0]  py_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   ebgs_tag_type        p1_tag_ff;
   ebgs_tag_type        p1_tag_in;

   // Accumulators and results.
   logic signed [SUM_W-1:0]   sx_ff;
   logic signed [SUM_W-1:0]   sx_in;
   logic signed [SUM_W-1:0]   sy_ff;
   logic signed [SUM_W-1:0]   sy_in;
   logic [CNT_W-1:0]          lost_ff;
   logic [CNT_W-1:0]          lost_in;
   logic signed [COORD_W-1:0] ax_ff;
   logic signed [COORD_W-1:0] ay_ff;
   logic signed [COORD_W-1:0] lk_x_ff [2];
   logic signed [COORD_W-1:0] lk_y_ff [2];

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_gaze_x_ff;
   logic signed [COORD_W-1:0] rsp_gaze_y_ff;
   logic                      rsp_blink_ff;

   // Sequencer outputs.
   ebgs_hist_cmd_type hist_cmd;
   logic              div_start;
   logic              out_load;
   logic              req_acc;

   // Unit connections.
   logic [CNT_W-1:0]          hist_count;
   logic [SAMPLE_W-1:0]       hist_rd_data;
   ebgs_map_stat_type         map_stat;
   logic signed [COORD_W-1:0] map_x;
   logic signed [COORD_W-1:0] map_y;
   logic                      div_done;
   logic signed [COORD_W-1:0] quot_x;
   logic signed [COORD_W-1:0] quot_y;

   // Window sizes, blink decision and the lost-tracking fallback.
   logic [CNT_W-1:0] nb;
   logic [CNT_W-1:0] nm;
   logic [CMP_W-1:0] lost_x10;
   logic [CMP_W-1:0] blink_thr;
   logic             fallback;
   logic             blink;

   assign req_acc = req_valid && req_ready;

   always_comb begin
      nb = (hist_count < CNT_W'(BLINK_WINDOW)) ? hist_count : CNT_W'(BLINK_WINDOW);
      nm = (hist_count < CNT_W'(MOVE_WINDOW)) ? hist_count : CNT_W'(MOVE_WINDOW);
      lost_x10  = CMP_W'(lost_ff) * CMP_W'(10);
      blink_thr = CMP_W'(ratio_ff) * CMP_W'(nb);
      fallback  = (ax_ff == '0) && (ay_ff == '0);
      blink     = (lost_x10 >= blink_thr) || fallback;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
         gain_ff  <= GAIN_RESET;
         bias_ff  <= BIAS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLINK_RATIO: ratio_ff <= csr_wdata[RATIO_W-1:0];
            CSR_GAZE_GAIN:   gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_VERT_BIAS:   bias_ff  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (CNT_W'(idx_ff) == hist_count - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_tag_ff.vld && !map_stat.vld) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready      = 1'b0;
      hist_cmd.push  = 1'b0;
      hist_cmd.rd_en = 1'b0;
      hist_cmd.eye   = eye_ff;
      div_start      = 1'b0;
      out_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready      = 1'b1;
         ST_PUSH:  hist_cmd.push  = 1'b1;
         ST_READ:  hist_cmd.rd_en = 1'b1;
         ST_DRAIN: ;
         ST_START: div_start      = 1'b1;
         ST_DIV:   ;
         ST_DONE:  out_load       = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         eye_ff <= req_eye_index;
         px_ff  <= req_pupil_in_x;
         py_ff  <= req_pupil_in_y;
      end
   end

   // Read index and the tag that follows each read through the memory.
   always_comb begin
      idx_in = idx_ff;
      if (hist_cmd.push) begin
         idx_in = '0;
      end else if (hist_cmd.rd_en) begin
         idx_in = idx_ff + 1'b1;
      end
      p1_tag_in.vld      = hist_cmd.rd_en;
      p1_tag_in.in_blink = CNT_W'(idx_ff) < nb;
      p1_tag_in.in_move  = CNT_W'(idx_ff) < nm;
   end

   // Accumulate mapped samples and lost flags.
   always_comb begin
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      lost_in = lost_ff;
      if (hist_cmd.push) begin
         sx_in   = '0;
         sy_in   = '0;
         lost_in = '0;
      end else if (map_stat.vld) begin
         sx_in   = sx_ff + SUM_W'(map_x);
         sy_in   = sy_ff + SUM_W'(map_y);
         lost_in = lost_ff + CNT_W'(map_stat.lost);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         p1_tag_ff <= '0;
      end else begin
         idx_ff    <= idx_in;
         p1_tag_ff <= p1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      lost_ff <= lost_in;
      if (div_done) begin
         ax_ff <= quot_x;
         ay_ff <= quot_y;
      end
   end

   // Last known position: replayed when both averages are zero, refreshed otherwise.
   always_ff @(posedge clock) begin
      if (reset) begin
         lk_x_ff[0] <= '0;
         lk_x_ff[1] <= '0;
         lk_y_ff[0] <= '0;
         lk_y_ff[1] <= '0;
      end else if (out_load && !fallback) begin
         lk_x_ff[eye_ff] <= ax_ff;
         lk_y_ff[eye_ff] <= ay_ff;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_gaze_x_ff <= fallback ? lk_x_ff[eye_ff] : ax_ff;
         rsp_gaze_y_ff <= fallback ? lk_y_ff[eye_ff] : ay_ff;
         rsp_blink_ff  <= blink;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_gaze_x = rsp_gaze_x_ff;
   assign rsp_gaze_y = rsp_gaze_y_ff;
   assign rsp_blink  = rsp_blink_ff;

   ebgs_hist #(
      .DEPTH(DEPTH)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hist_cmd),
      .sample  ({py_ff, px_ff}),
      .rd_index(idx_ff),
      .count   (hist_count),
      .rd_data (hist_rd_data)
   );

   ebgs_map u_map (
      .clock (clock),
      .reset (reset),
      .tag   (p1_tag_ff),
      .sample(hist_rd_data),
      .gain  (gain_ff),
      .bias  (bias_ff),
      .stat  (map_stat),
      .map_x (map_x),
      .map_y (map_y)
   );

   ebgs_div #(
      .DW(SUM_W),
      .VW(CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend_x(sx_ff),
      .dividend_y(sy_ff),
      .divisor   (nm),
      .done      (div_done),
      .quot_x    (quot_x),
      .quot_y    (quot_y)
   );

   // An accepted request always starts with the history push.
   `ASSERT_NEXT(a_acc_push, clock, reset, req_acc, state_ff == ST_PUSH, "accept not followed by push")
   // Mapped samples only arrive while the history is being read out.
   `ASSERT_ALWAYS(a_map_window, clock, reset, !map_stat.vld || state_ff == ST_READ || state_ff == ST_DRAIN, "mapped sample outside read phase")
   // The divider reports completion only while the sequencer waits for it.
   `ASSERT_ALWAYS(a_div_done, clock, reset, !div_done || state_ff == ST_DIV, "divider done outside wait state")
   // The history is never empty once the readout starts.
   `ASSERT_ALWAYS(a_count_nz, clock, reset, state_ff != ST_READ || hist_count != '0, "empty history during readout")
   // Lost samples cannot outnumber the blink window.
   `ASSERT_ALWAYS(a_lost_le_nb, clock, reset, state_ff != ST_DONE || lost_ff <= nb, "lost count exceeds window")

endmodule

// ----- sim/ebgs_gaze_checker.sv -----
`timescale 1ns / 1ps

module ebgs_gaze_checker
   import ebgs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_eye_index,
   input  logic [COORD_W-1:0]        req_pupil_in_x,
   input  logic [COORD_W-1:0]        req_pupil_in_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [COORD_W-1:0] rsp_gaze_x,
   input  logic signed [COORD_W-1:0] rsp_gaze_y,
   input  logic                      rsp_blink,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [BIAS_W-1:0]         csr_wdata,
   output int                        mismatches,
   output int                        pending
);

   localparam int BLINK_SPAN    = 7;
   localparam int MOVE_SPAN     = 5;
   localparam int HISTORY_DEPTH = (BLINK_SPAN > MOVE_SPAN) ? BLINK_SPAN : MOVE_SPAN;

   typedef struct {
      logic signed [COORD_W-1:0] gaze_x;
      logic signed [COORD_W-1:0] gaze_y;
      logic                      blink;
   } gaze_result_type;

   // Mirror of the configuration registers.
   logic [RATIO_W-1:0]       ratio_setting;
   logic [GAIN_W-1:0]        gain_setting;
   logic signed [BIAS_W-1:0] bias_setting;

   // Per-eye history (newest first, x low, y high), fill level and last-known gaze.
   logic [SAMPLE_W-1:0]       gaze_history [2][HISTORY_DEPTH];
   int                        held_count [2];
   logic signed [COORD_W-1:0] last_x [2];
   logic signed [COORD_W-1:0] last_y [2];

   gaze_result_type expected_gaze [$];
   int              response_count;

   function automatic int clamp_q15(int t);
      if (t > 32767) return 32767;
      if (t < -32768) return -32768;
      return t;
   endfunction

   // Horizontal mapping: a lost coordinate gives zero, otherwise the gained, centered value.
   function automatic int map_horizontal(logic [COORD_W-1:0] v);
      if (v == 0) return 0;
      return clamp_q15(int'(gain_setting) * (int'(v) - 32768));
   endfunction

   // Vertical mapping adds the bias and flips the sign; the most negative value saturates.
   function automatic int map_vertical(logic [COORD_W-1:0] v);
      int t;
      if (v == 0) return 0;
      t = clamp_q15(int'(gain_setting) * (int'(v) - 32768) + int'(bias_setting));
      return (t == -32768) ? 32767 : -t;
   endfunction

   // Pushes one sample into its eye's history and works out the smoothed gaze and blink.
   function automatic gaze_result_type smooth_sample(logic eye, logic [COORD_W-1:0] px,
                                                     logic [COORD_W-1:0] py);
      gaze_result_type r;
      int i, n_blink, n_move, lost, sum_x, sum_y, avg_x, avg_y;
      for (i = HISTORY_DEPTH - 1; i > 0; i--) gaze_history[eye][i] = gaze_history[eye][i-1];
      gaze_history[eye][0] = {py, px};
      if (held_count[eye] < HISTORY_DEPTH) held_count[eye]++;

      // Blink vote over the newest samples.
      n_blink = (held_count[eye] < BLINK_SPAN) ? held_count[eye] : BLINK_SPAN;
      lost = 0;
      for (i = 0; i < n_blink; i++) if (gaze_history[eye][i] == 0) lost++;
      r.blink = (10 * lost >= int'(ratio_setting) * n_blink);

      // Gaze average, truncated toward zero.
      n_move = (held_count[eye] < MOVE_SPAN) ? held_count[eye] : MOVE_SPAN;
      sum_x = 0;
      sum_y = 0;
      for (i = 0; i < n_move; i++) begin
         sum_x += map_horizontal(gaze_history[eye][i][COORD_W-1:0]);
         sum_y += map_vertical(gaze_history[eye][i][SAMPLE_W-1:COORD_W]);
      end
      avg_x = sum_x / n_move;
      avg_y = sum_y / n_move;

      // With no usable gaze the last-known position is held and the eye counts as closed.
      if (avg_x == 0 && avg_y == 0) begin
         avg_x = last_x[eye];
         avg_y = last_y[eye];
         r.blink = 1'b1;
      end
      if (avg_x != 0 || avg_y != 0) begin
         last_x[eye] = avg_x[COORD_W-1:0];
         last_y[eye] = avg_y[COORD_W-1:0];
      end
      r.gaze_x = avg_x[COORD_W-1:0];
      r.gaze_y = avg_y[COORD_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      gaze_result_type seen, want;
      int e, k;
      if (reset) begin
         ratio_setting = RATIO_RESET;
         gain_setting  = GAIN_RESET;
         bias_setting  = BIAS_RESET;
         for (e = 0; e < 2; e++) begin
            held_count[e] = 0;
            last_x[e] = '0;
            last_y[e] = '0;
            for (k = 0; k < HISTORY_DEPTH; k++) gaze_history[e][k] = '0;
         end
         expected_gaze.delete();
         response_count = 0;
      end else begin
         // Responses are checked first so that a stray one is never matched to a request
         // accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            seen.gaze_x = rsp_gaze_x;
            seen.gaze_y = rsp_gaze_y;
            seen.blink  = rsp_blink;
            if (expected_gaze.size() == 0) begin
               if (mismatches < 10)
                  $display("response %0d with no request pending: x=%0d y=%0d blink=%0b",
                           response_count, seen.gaze_x, seen.gaze_y, seen.blink);
               mismatches++;
            end else begin
               want = expected_gaze.pop_front();
               if (seen.gaze_x !== want.gaze_x || seen.gaze_y !== want.gaze_y ||
                   seen.blink !== want.blink) begin
                  if (mismatches < 10)
                     $display("response %0d: expected x=%0d y=%0d blink=%0b, got x=%0d y=%0d blink=%0b",
                              response_count, want.gaze_x, want.gaze_y, want.blink,
                              seen.gaze_x, seen.gaze_y, seen.blink);
                  mismatches++;
               end
            end
            response_count++;
         end

         if (req_valid && req_ready)
            expected_gaze.push_back(smooth_sample(req_eye_index, req_pupil_in_x,
                                                  req_pupil_in_y));

         if (csr_we) begin
            case (csr_index)
               CSR_BLINK_RATIO: ratio_setting = csr_wdata[RATIO_W-1:0];
               CSR_GAZE_GAIN:   gain_setting  = csr_wdata[GAIN_W-1:0];
               CSR_VERT_BIAS:   bias_setting  = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = expected_gaze.size();
   end

endmodule

// ----- sim/tb_eye_blink_and_gaze_smoother.sv -----
`timescale 1ns / 1ps

module tb_eye_blink_and_gaze_smoother;
   import ebgs_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 225;
   localparam int PHASE_COUNT  = 8;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_eye_index = 1'b0;
   logic [COORD_W-1:0]        req_pupil_in_x = '0;
   logic [COORD_W-1:0]        req_pupil_in_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_gaze_x;
   logic signed [COORD_W-1:0] rsp_gaze_y;
   logic                      rsp_blink;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [BIAS_W-1:0]         csr_wdata = '0;

   int mismatches;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   eye_blink_and_gaze_smoother uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_eye_index  (req_eye_index),
      .req_pupil_in_x (req_pupil_in_x),
      .req_pupil_in_y (req_pupil_in_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_gaze_x     (rsp_gaze_x),
      .rsp_gaze_y     (rsp_gaze_y),
      .rsp_blink      (rsp_blink),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   ebgs_gaze_checker gaze_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_eye_index  (req_eye_index),
      .req_pupil_in_x (req_pupil_in_x),
      .req_pupil_in_y (req_pupil_in_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_gaze_x     (rsp_gaze_x),
      .rsp_gaze_y     (rsp_gaze_y),
      .rsp_blink      (rsp_blink),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   // The response side stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("eye_blink_and_gaze_smoother test failed");
         $finish;
      end
   end

   // Presents one request and holds it until it is accepted.
   task automatic send_sample(logic eye, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid      <= 1'b1;
      req_eye_index  <= eye;
      req_pupil_in_x <= px;
      req_pupil_in_y <= py;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drops valid and waits until every response has come back.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [BIAS_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic apply_settings(logic [RATIO_W-1:0] ratio, logic [GAIN_W-1:0] gain,
                                 logic [BIAS_W-1:0] bias);
      write_reg(CSR_BLINK_RATIO, BIAS_W'(ratio));
      write_reg(CSR_GAZE_GAIN, BIAS_W'(gain));
      write_reg(CSR_VERT_BIAS, bias);
   endtask

   // Coordinates weighted toward lost, edge and near-center values.
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(9))
         0: return '0;
         1: return COORD_W'($urandom_range(16, 1));
         2: return COORD_W'($urandom_range(65535, 65520));
         3: return COORD_W'($urandom_range(33280, 32256));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Random samples with runs of lost tracking on one eye to drive the blink vote.
   task automatic run_phase(int count);
      int k, burst_left;
      logic burst_eye;
      burst_left = 0;
      burst_eye  = 1'b0;
      for (k = 0; k < count; k++) begin
         if (burst_left > 0) begin
            send_sample(burst_eye, '0, '0);
            burst_left--;
         end else begin
            case ($urandom_range(19))
               0: begin
                  burst_eye  = 1'($urandom_range(1));
                  burst_left = $urandom_range(9, 3);
                  send_sample(burst_eye, '0, '0);
               end
               1, 2, 3: send_sample(1'($urandom_range(1)), '0, '0);
               default: send_sample(1'($urandom_range(1)), pick_coord(), pick_coord());
            endcase
         end
      end
   endtask

   initial begin
      int phase, n;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed requests at reset settings: lost first sample, extremes, center,
      // one coordinate lost, and a full history of lost samples on one eye.
      send_sample(1'b0, 16'd0, 16'd0);
      send_sample(1'b0, 16'hFFFF, 16'hFFFF);
      send_sample(1'b0, 16'd1, 16'd1);
      send_sample(1'b0, 16'h8000, 16'h8000);
      send_sample(1'b1, 16'd0, 16'hFFFF);
      send_sample(1'b1, 16'hFFFF, 16'd0);
      send_sample(1'b1, 16'd1, 16'h8000);
      for (n = 0; n < 8; n++) send_sample(1'b0, 16'd0, 16'd0);
      send_sample(1'b1, 16'hAAAA, 16'h5555);
      send_sample(1'b1, 16'h5555, 16'hAAAA);

      // Zero ratio, zero gain and the largest bias.
      drain_responses();
      apply_settings(4'd0, 4'd0, 19'h3FFFF);
      send_sample(1'b0, 16'h1234, 16'h8000);
      send_sample(1'b1, 16'd0, 16'd0);
      send_sample(1'b0, 16'hFFFF, 16'd1);

      // Ratio above ten, the largest gain and the most negative bias.
      drain_responses();
      apply_settings(4'd15, 4'd15, 19'h40000);
      send_sample(1'b0, 16'hFFFF, 16'hFFFF);
      send_sample(1'b0, 16'd1, 16'd1);
      send_sample(1'b1, 16'd0, 16'd0);
      send_sample(1'b1, 16'h7FFF, 16'h8001);

      // Random phases, cycling through the idle patterns and register settings.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_responses();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         case (phase)
            0: apply_settings(4'd7, 4'd5, 19'h10000);
            1: apply_settings(4'd0, 4'd15, 19'h40000);
            2: apply_settings(4'd15, 4'd0, 19'h3FFFF);
            3: apply_settings(4'd10, 4'd1, 19'h20000);
            4: apply_settings(4'd1, 4'd15, 19'h60000);
            default: apply_settings(4'($urandom_range(15)), 4'($urandom_range(15)),
                                    19'($urandom));
         endcase
         run_phase(PHASE_ITEMS);
      end

      drain_responses();
      repeat (60) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("eye_blink_and_gaze_smoother test passed");
      else
         $display("eye_blink_and_gaze_smoother test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/ebgs_pkg.sv
design/ebgs_hist.sv
design/ebgs_map.sv
design/ebgs_div.sv
design/eye_blink_and_gaze_smoother.sv
sim/ebgs_gaze_checker.sv
sim/tb_eye_blink_and_gaze_smoother.sv
